// ===== rtl/huffman_table_decoder_assert.svh =====
// assertion macros for the huffman table decoder
`ifndef HUFFMAN_TABLE_DECODER_ASSERT_SVH
`define HUFFMAN_TABLE_DECODER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define HTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/htd_pkg.sv =====
// shared types, codes and helpers of the huffman table decoder
package htd_pkg;

  localparam int DEF_MAX_CODE_LENGTH = 32;
  localparam int DEF_SYMBOL_COUNT    = 256;

  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_END_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LEN  = 1'd1;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  localparam logic [1:0] STAT_SYMBOL  = 2'd0;
  localparam logic [1:0] STAT_MARKER  = 2'd1;
  localparam logic [1:0] STAT_NO_END  = 2'd2;
  localparam logic [1:0] STAT_TOOLONG = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_CHECK,
    ST_RD,
    ST_CMP,
    ST_DELIVER,
    ST_FLUSH
  } state_t;

  // keep only the low len bits of a code
  function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] bits,
                                                   input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] keep;
    keep = ~({CODE_W{1'b1}} << len);
    return bits & keep;
  endfunction

endpackage

// ===== rtl/huffman_table_decoder.sv =====
// top level of the huffman table decoder
// Huffman decoder driven by a loaded code table. A load transaction (action 0) writes one
// entry: symbol, right-aligned code bits and code length (0 = unused). A data transaction
// (action 1) carries one byte that is shifted into the bit buffer most significant bit
// first, one bit per step. After each bit the buffer is checked against the end marker
// from configuration, then the table is scanned entry by entry from symbol 0 through the
// single registered read port of the table memory. Results carry status, symbol and last
// (set on the final result of each transaction). An end-of-input transaction (action 2)
// gives status 2. After the end marker or end of input every transaction is taken and
// dropped until reset. Table entries reset to unused through valid bits, so there is no
// clearing pass. The input is stalled while a transaction is in progress.
module huffman_table_decoder import htd_pkg::*; #(
  parameter int MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH,
  parameter int SYMBOL_COUNT    = DEF_SYMBOL_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_data_byte,
  input  logic [7:0]           in_entry_symbol,
  input  logic [CODE_W-1:0]    in_entry_code_bits,
  input  logic [LEN_W-1:0]     in_entry_code_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [7:0]           out_symbol,
  output logic                 out_last
);

  localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_CODE_LENGTH + 1);
  localparam int CMP_W = 7;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_CODE_LENGTH);
  localparam logic [SYM_W-1:0] LAST_IDX = SYM_W'(SYMBOL_COUNT - 1);

  state_t state_r, state_nxt;

  // byte shift register and bit buffer
  logic [7:0] byte_r, byte_nxt;
  logic [3:0] bits_left_r, bits_left_nxt;
  logic [MAX_CODE_LENGTH-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SYM_W-1:0] idx_r, idx_nxt;
  logic finished_r, finished_nxt;

  // configuration
  logic [CODE_W-1:0] end_bits_r;
  logic [LEN_W-1:0]  end_len_r;

  // newest result, held result and output register
  logic [1:0] res_status_r, res_status_nxt;
  logic [7:0] res_symbol_r, res_symbol_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic [1:0] pend_status_r, pend_status_nxt;
  logic [7:0] pend_symbol_r, pend_symbol_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [7:0] out_symbol_r, out_symbol_nxt;
  logic       out_last_r, out_last_nxt;

  // table port
  logic              tbl_we;
  logic [CODE_W-1:0] tbl_bits;
  logic [LEN_W-1:0]  tbl_len;

  logic in_take, out_free, end_hit, tbl_hit, sym_in_range;
  logic [CODE_W-1:0] end_masked;

  htd_table #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (in_entry_symbol[SYM_W-1:0]),
    .wr_bits (in_entry_code_bits),
    .wr_len  (in_entry_code_length),
    .rd_addr (idx_r),
    .rd_bits (tbl_bits),
    .rd_len  (tbl_len)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  assign sym_in_range = ({1'b0, in_entry_symbol} < 9'(SYMBOL_COUNT));
  assign end_masked   = mask_code(end_bits_r, end_len_r);

  // exact match: same length as the buffer and same bits
  assign end_hit = (end_len_r != '0) && (CMP_W'(end_len_r) <= MAX_LEN) &&
                   (CMP_W'(end_len_r) == CMP_W'(cnt_r)) &&
                   (buf_r == MAX_CODE_LENGTH'(end_masked));
  assign tbl_hit = (tbl_len != '0) && (CMP_W'(tbl_len) <= MAX_LEN) &&
                   (CMP_W'(tbl_len) == CMP_W'(cnt_r)) &&
                   (buf_r == MAX_CODE_LENGTH'(tbl_bits));

  always_comb begin
    state_nxt       = state_r;
    byte_nxt        = byte_r;
    bits_left_nxt   = bits_left_r;
    buf_nxt         = buf_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    finished_nxt    = finished_r;
    res_status_nxt  = res_status_r;
    res_symbol_nxt  = res_symbol_r;
    pend_valid_nxt  = pend_valid_r;
    pend_status_nxt = pend_status_r;
    pend_symbol_nxt = pend_symbol_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_symbol_nxt  = out_symbol_r;
    out_last_nxt    = out_last_r;
    tbl_we          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take && !finished_r) begin
          case (in_action)
            ACT_LOAD: tbl_we = sym_in_range;
            ACT_DATA: begin
              byte_nxt      = in_data_byte;
              bits_left_nxt = 4'd8;
              state_nxt     = ST_SHIFT;
            end
            ACT_END: begin
              pend_valid_nxt  = 1'b1;
              pend_status_nxt = STAT_NO_END;
              pend_symbol_nxt = '0;
              finished_nxt    = 1'b1;
              state_nxt       = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        // one compressed bit enters the buffer
        buf_nxt       = {buf_r[MAX_CODE_LENGTH-2:0], byte_r[7]};
        byte_nxt      = {byte_r[6:0], 1'b0};
        cnt_nxt       = cnt_r + 1'b1;
        bits_left_nxt = bits_left_r - 1'b1;
        state_nxt     = ST_CHECK;
      end
      ST_CHECK: begin
        idx_nxt = '0;
        if (end_hit) begin
          res_status_nxt = STAT_MARKER;
          res_symbol_nxt = '0;
          finished_nxt   = 1'b1;
          buf_nxt        = '0;
          cnt_nxt        = '0;
          state_nxt      = ST_DELIVER;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (tbl_hit) begin
          res_status_nxt = STAT_SYMBOL;
          res_symbol_nxt = 8'(idx_r);
          buf_nxt        = '0;
          cnt_nxt        = '0;
          state_nxt      = ST_DELIVER;
        end else if (idx_r != LAST_IDX) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end else if (CMP_W'(cnt_r) >= MAX_LEN) begin
          res_status_nxt = STAT_TOOLONG;
          res_symbol_nxt = '0;
          buf_nxt        = '0;
          cnt_nxt        = '0;
          state_nxt      = ST_DELIVER;
        end else begin
          state_nxt = (bits_left_r == '0) ? ST_FLUSH : ST_SHIFT;
        end
      end
      ST_DELIVER: begin
        // the held result goes out with last low once a newer one exists
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pend_status_r;
            out_symbol_nxt = pend_symbol_r;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt  = 1'b1;
          pend_status_nxt = res_status_r;
          pend_symbol_nxt = res_symbol_r;
          state_nxt = (finished_r || bits_left_r == '0) ? ST_FLUSH : ST_SHIFT;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_symbol_nxt = pend_symbol_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      buf_r        <= '0;
      cnt_r        <= '0;
      finished_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      end_bits_r   <= '0;
      end_len_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      buf_r        <= buf_nxt;
      cnt_r        <= cnt_nxt;
      finished_r   <= finished_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en && cfg_index == CFG_END_BITS) end_bits_r <= cfg_wdata;
      if (cfg_wr_en && cfg_index == CFG_END_LEN)  end_len_r  <= cfg_wdata[LEN_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    bits_left_r   <= bits_left_nxt;
    idx_r         <= idx_nxt;
    res_status_r  <= res_status_nxt;
    res_symbol_r  <= res_symbol_nxt;
    pend_status_r <= pend_status_nxt;
    pend_symbol_r <= pend_symbol_nxt;
    out_status_r  <= out_status_nxt;
    out_symbol_r  <= out_symbol_nxt;
    out_last_r    <= out_last_nxt;
  end

`include "huffman_table_decoder_assert.svh"

  `HTD_ASSERT_IMP(a_cnt_bound, 1'b1, CMP_W'(cnt_r) <= MAX_LEN, "bit count above max code length")
  `HTD_ASSERT_NXT(a_fin_sticky, finished_r, finished_r, "finished flag dropped before reset")
  `HTD_ASSERT_IMP(a_idle_empty, state_r == ST_IDLE, !pend_valid_r, "held result left in idle")
  `HTD_ASSERT_IMP(a_scan_bits, state_r == ST_CMP, cnt_r != '0, "table scan with empty buffer")

endmodule

// ===== rtl/htd_table.sv =====
// code table memory with per-entry valid bits and registered read
module htd_table import htd_pkg::*; #(
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
  localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [SYM_W-1:0]  wr_addr,
  input  logic [CODE_W-1:0] wr_bits,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic [SYM_W-1:0]  rd_addr,
  output logic [CODE_W-1:0] rd_bits,
  output logic [LEN_W-1:0]  rd_len
);

  logic [CODE_W-1:0] bits_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;
  logic [CODE_W-1:0] rd_bits_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bits_mem[wr_addr] <= mask_code(wr_bits, wr_len);
      len_mem[wr_addr]  <= wr_len;
    end
    rd_bits_r <= bits_mem[rd_addr];
    rd_len_r  <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // an entry never written reads as unused
  assign rd_bits = rd_bits_r;
  assign rd_len  = rd_valid_r ? rd_len_r : '0;

endmodule
